// ===== src/assert_macros.svh =====
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property that holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("assertion failed");
// Same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== src/bna_pkg.sv =====
// Types, constants and saturating adders for the boid neighbour aggregator
package bna_pkg;

  localparam int MAX_BOIDS = 1024;
  localparam int AddrW     = $clog2(MAX_BOIDS);
  localparam int CntW      = $clog2(MAX_BOIDS + 1);

  localparam logic [7:0]  REG_VIEW_RADIUS  = 8'd0;
  localparam logic [7:0]  REG_AVOID_RADIUS = 8'd1;
  localparam logic [27:0] VIEW_RESET       = 28'd327680;
  localparam logic [27:0] AVOID_RESET      = 28'd65536;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [3:0] {
    S_IDLE, S_VR, S_AR, S_OWN, S_OWNC, S_RD, S_OFF, S_SQ, S_CMP, S_DIV, S_AM, S_DONE
  } state_e;

  typedef struct packed {
    logic signed [15:0] dir_z;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_x;
    logic signed [28:0] pos_z;
    logic signed [28:0] pos_y;
    logic signed [28:0] pos_x;
  } boid_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // returns {clamped, sum}
  function automatic logic [48:0] sat_add48(input logic signed [47:0] acc,
                                            input logic signed [47:0] dlt);
    logic signed [48:0] s;
    s = {acc[47], acc} + {dlt[47], dlt};
    if (s[48] != s[47]) return {1'b1, s[48], {47{~s[48]}}};
    return {1'b0, s[47:0]};
  endfunction

  function automatic logic [32:0] sat_add32(input logic signed [31:0] acc,
                                            input logic signed [31:0] dlt);
    logic signed [32:0] s;
    s = {acc[31], acc} + {dlt[31], dlt};
    if (s[32] != s[31]) return {1'b1, s[32], {31{~s[32]}}};
    return {1'b0, s[31:0]};
  endfunction

endpackage

// ===== src/bna_if.sv =====
// Handshake channels of the boid neighbour aggregator
interface bna_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [28:0] pos_x;
  logic signed [28:0] pos_y;
  logic signed [28:0] pos_z;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] dir_z;
  logic [9:0]         query_index;
  modport source (output valid, command, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z,
                  query_index, input ready);
  modport sink (input valid, command, pos_x, pos_y, pos_z, dir_x, dir_y, dir_z,
                query_index, output ready);
endinterface

interface bna_out_if;
  logic               valid;
  logic               ready;
  logic [9:0]         neighbour_count;
  logic signed [31:0] heading_sum_x;
  logic signed [31:0] heading_sum_y;
  logic signed [31:0] heading_sum_z;
  logic signed [47:0] centre_sum_x;
  logic signed [47:0] centre_sum_y;
  logic signed [47:0] centre_sum_z;
  logic signed [47:0] avoid_sum_x;
  logic signed [47:0] avoid_sum_y;
  logic signed [47:0] avoid_sum_z;
  logic               saturated;
  logic               bad_index;
  modport source (output valid, neighbour_count, heading_sum_x, heading_sum_y,
                  heading_sum_z, centre_sum_x, centre_sum_y, centre_sum_z, avoid_sum_x,
                  avoid_sum_y, avoid_sum_z, saturated, bad_index, input ready);
  modport sink (input valid, neighbour_count, heading_sum_x, heading_sum_y,
                heading_sum_z, centre_sum_x, centre_sum_y, centre_sum_z, avoid_sum_x,
                avoid_sum_y, avoid_sum_z, saturated, bad_index, output ready);
endinterface

interface bna_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [27:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/bna_store.sv =====
// Boid memory: one word per boid, position and direction together
module bna_store
  import bna_pkg::*;
(
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  boid_t            wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output boid_t            rdata_o
);

  boid_t mem_q [MAX_BOIDS];
  boid_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/bna_div.sv =====
// Restoring divider, one quotient bit a cycle: 2^62 / divisor
module bna_div
  import bna_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [59:0] divisor_i,
  output div_stat_t   stat_o,
  output logic [62:0] quot_o
);

  logic [59:0] div_q;
  logic [60:0] rem_q;
  logic [62:0] quot_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [60:0] rem_sh;
  logic        fits;

  // dividend has only bit 62 set
  assign rem_sh = {rem_q[59:0], (cnt_q == 6'd62)};
  assign fits   = rem_sh >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd62;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q  <= divisor_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= fits ? rem_sh - {1'b0, div_q} : rem_sh;
      quot_q <= {quot_q[61:0], fits};
    end
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign quot_o = quot_q;

endmodule

// ===== src/boid_neighbour_aggregation_top.sv =====
// Top level: command decode, query sequencer and shared multiplier
// Load, clear and ignored commands leave the sequencer idle, so the input stays ready.
// Query: an index past the flock skips to the result; else square both radii, read the own entry,
// then per other boid read it, sum its squared offsets and compare them with the radii; one in both
// radii and not coincident also runs the 63-step bit-serial divider and 32x32 avoidance products.
// Reset is asynchronous, active low; the flock is empty and radii take defaults.
module boid_neighbour_aggregation_top
  import bna_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  bna_in_if.sink   in_i,
  bna_out_if.source out_o,
  bna_cfg_if.sink  cfg_i
);
  `include "assert_macros.svh"

  state_e state_q, state_d;

  logic [27:0]         view_q, avoid_q;
  logic [CntW-1:0]     count_q;
  logic [CntW-1:0]     b_q;
  logic [9:0]          qi_q;
  logic [2:0]          k_q;
  logic signed [28:0]  own_q [3];
  logic [29:0]         mag_q [3];
  logic                neg_q [3];
  logic [59:0]         d_q;
  logic [55:0]         vr2_q, ar2_q;
  logic [63:0]         prod_q;
  logic [61:0]         psum_q;
  logic [9:0]          nc_q;
  logic signed [31:0]  head_q [3];
  logic signed [47:0]  cen_q [3];
  logic signed [47:0]  avo_q [3];
  logic                sat_q, bad_q;

  logic                out_valid_q;
  logic [9:0]          o_nc_q;
  logic signed [31:0]  o_head_q [3];
  logic signed [47:0]  o_cen_q [3];
  logic signed [47:0]  o_avo_q [3];
  logic                o_sat_q, o_bad_q;

  logic        in_acc, is_self, at_end, in_view, in_avoid, out_free;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic        mem_we, mem_re;
  logic [AddrW-1:0] mem_raddr;
  boid_t       wdata, rdata;
  logic        div_start;
  div_stat_t   div_stat;
  logic [62:0] recip;
  logic [1:0]  am_ax;
  logic [63:0] am_full;
  logic [33:0] am_t;
  cmd_e        cmd;

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign cmd         = cmd_e'(in_i.command);
  assign cfg_i.ready = 1'b1;
  assign is_self     = (32'(b_q) == 32'(qi_q));
  assign at_end      = (b_q == count_q);
  assign in_view     = d_q < 60'(vr2_q);
  assign in_avoid    = (d_q < 60'(ar2_q)) && (d_q != '0);
  assign out_free    = !out_valid_q || out_o.ready;

  assign wdata = '{dir_z: in_i.dir_z, dir_y: in_i.dir_y, dir_x: in_i.dir_x,
                   pos_z: in_i.pos_z, pos_y: in_i.pos_y, pos_x: in_i.pos_x};
  assign mem_we    = in_acc && (cmd == CMD_LOAD) && (32'(count_q) < MAX_BOIDS);
  assign mem_re    = (state_q == S_OWN) || (state_q == S_RD && !at_end && !is_self);
  assign mem_raddr = (state_q == S_OWN) ? AddrW'(qi_q) : b_q[AddrW-1:0];
  assign div_start = (state_q == S_CMP) && in_view && in_avoid;

  bna_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rdata)
  );

  bna_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (d_q),
    .stat_o    (div_stat),
    .quot_o    (recip)
  );

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_VR: begin
        mul_a = 32'(view_q);
        mul_b = 32'(view_q);
      end
      S_AR: begin
        mul_a = 32'(avoid_q);
        mul_b = 32'(avoid_q);
      end
      S_SQ: begin
        if (k_q < 3'd3) begin
          mul_a = 32'(mag_q[k_q[1:0]]);
          mul_b = 32'(mag_q[k_q[1:0]]);
        end
      end
      S_AM: begin
        if (k_q < 3'd6) begin
          mul_a = 32'(mag_q[2'(k_q >> 1)]);
          mul_b = k_q[0] ? 32'(recip[62:32]) : recip[31:0];
        end
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // avoidance term: product of the earlier step k-1, even steps close an axis
  assign am_ax   = 2'((k_q - 3'd1) >> 1);
  assign am_full = 64'(psum_q) + {prod_q[31:0], 32'b0};
  assign am_t    = am_full[63:30];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && cmd == CMD_QUERY) begin
          if (32'(in_i.query_index) >= 32'(count_q)) state_d = S_DONE;
          else                                       state_d = S_VR;
        end
      end
      S_VR:   state_d = S_AR;
      S_AR:   state_d = S_OWN;
      S_OWN:  state_d = S_OWNC;
      S_OWNC: state_d = S_RD;
      S_RD: begin
        if (at_end)        state_d = S_DONE;
        else if (!is_self) state_d = S_OFF;
      end
      S_OFF:  state_d = S_SQ;
      S_SQ:   if (k_q == 3'd3) state_d = S_CMP;
      S_CMP:  state_d = div_start ? S_DIV : S_RD;
      S_DIV:  if (div_stat.done) state_d = S_AM;
      S_AM:   if (k_q == 3'd6) state_d = S_RD;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_q      <= VIEW_RESET;
      avoid_q     <= AVOID_RESET;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == REG_VIEW_RADIUS)  view_q  <= cfg_i.data;
        if (cfg_i.index == REG_AVOID_RADIUS) avoid_q <= cfg_i.data;
      end
      if (mem_we) count_q <= count_q + 1'b1;
      else if (in_acc && cmd == CMD_CLEAR) count_q <= '0;
      if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
      else if (out_o.ready)              out_valid_q <= 1'b0;
    end
  end

  // query datapath
  always_ff @(posedge clk_i) begin
    logic [32:0] h;
    logic [48:0] c;
    logic [48:0] v;
    logic signed [29:0] df;
    logic sat;
    prod_q <= mul_p;
    case (state_q)
      S_IDLE: begin
        if (in_acc && cmd == CMD_QUERY) begin
          qi_q  <= in_i.query_index;
          bad_q <= 32'(in_i.query_index) >= 32'(count_q);
          nc_q  <= '0;
          sat_q <= 1'b0;
          for (int a = 0; a < 3; a++) begin
            head_q[a] <= '0;
            cen_q[a]  <= '0;
            avo_q[a]  <= '0;
          end
        end
      end
      S_AR:  vr2_q <= prod_q[55:0];
      S_OWN: ar2_q <= prod_q[55:0];
      S_OWNC: begin
        own_q[0] <= rdata.pos_x;
        own_q[1] <= rdata.pos_y;
        own_q[2] <= rdata.pos_z;
        b_q      <= '0;
      end
      S_RD: if (!at_end && is_self) b_q <= b_q + 1'b1;
      S_OFF: begin
        for (int a = 0; a < 3; a++) begin
          case (a)
            0:       df = 30'(rdata.pos_x) - 30'(own_q[0]);
            1:       df = 30'(rdata.pos_y) - 30'(own_q[1]);
            default: df = 30'(rdata.pos_z) - 30'(own_q[2]);
          endcase
          neg_q[a] <= df[29];
          mag_q[a] <= df[29] ? 30'(-df) : 30'(df);
        end
        d_q <= '0;
        k_q <= '0;
      end
      S_SQ: begin
        if (k_q != 3'd0) d_q <= d_q + 60'(prod_q);
        k_q <= k_q + 3'd1;
      end
      S_CMP: begin
        sat = sat_q;
        if (!div_start) b_q <= b_q + 1'b1;
        if (in_view) begin
          if (nc_q != 10'd1023) nc_q <= nc_q + 10'd1;
          else                  sat = 1'b1;
          for (int a = 0; a < 3; a++) begin
            case (a)
              0: begin
                h = sat_add32(head_q[a], 32'(rdata.dir_x));
                c = sat_add48(cen_q[a], 48'(rdata.pos_x));
              end
              1: begin
                h = sat_add32(head_q[a], 32'(rdata.dir_y));
                c = sat_add48(cen_q[a], 48'(rdata.pos_y));
              end
              default: begin
                h = sat_add32(head_q[a], 32'(rdata.dir_z));
                c = sat_add48(cen_q[a], 48'(rdata.pos_z));
              end
            endcase
            head_q[a] <= h[31:0];
            cen_q[a]  <= c[47:0];
            if (h[32] || c[48]) sat = 1'b1;
          end
        end
        sat_q <= sat;
        k_q <= '0;
      end
      S_AM: begin
        k_q <= k_q + 3'd1;
        if (k_q != 3'd0) begin
          if (!k_q[0]) begin
            // away from the neighbour: subtract the term for a positive offset
            v = sat_add48(avo_q[am_ax],
                          neg_q[am_ax] ? 48'(am_t) : -48'(am_t));
            avo_q[am_ax] <= v[47:0];
            if (v[48]) sat_q <= 1'b1;
          end else begin
            psum_q <= prod_q[61:0];
          end
        end
        if (k_q == 3'd6) b_q <= b_q + 1'b1;
      end
      S_DONE: begin
        if (out_free) begin
          o_nc_q  <= nc_q;
          o_sat_q <= sat_q;
          o_bad_q <= bad_q;
          for (int a = 0; a < 3; a++) begin
            o_head_q[a] <= head_q[a];
            o_cen_q[a]  <= cen_q[a];
            o_avo_q[a]  <= avo_q[a];
          end
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.neighbour_count = o_nc_q;
  assign out_o.heading_sum_x   = o_head_q[0];
  assign out_o.heading_sum_y   = o_head_q[1];
  assign out_o.heading_sum_z   = o_head_q[2];
  assign out_o.centre_sum_x    = o_cen_q[0];
  assign out_o.centre_sum_y    = o_cen_q[1];
  assign out_o.centre_sum_z    = o_cen_q[2];
  assign out_o.avoid_sum_x     = o_avo_q[0];
  assign out_o.avoid_sum_y     = o_avo_q[1];
  assign out_o.avoid_sum_z     = o_avo_q[2];
  assign out_o.saturated       = o_sat_q;
  assign out_o.bad_index       = o_bad_q;

  `ASSERT_ALWAYS(a_count_bound, 32'(count_q) <= MAX_BOIDS)
  `ASSERT_IMPL(a_div_live, state_q == S_DIV, div_stat.busy || div_stat.done)
  `ASSERT_NEXT(a_out_from_done, !out_valid_q && state_q != S_DONE, !out_valid_q)
  `ASSERT_IMPL(a_walk_bound, state_q == S_OFF || state_q == S_CMP, b_q < count_q)

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the boid neighbour aggregator: directed table, then random flocks
module tb_top;
  import bna_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  CMD_NOISE = 2'd3;
  localparam logic [27:0] RADIUS_MAX = 28'hFFFFFFF;
  localparam longint      ONE_Q16 = 65536;

  typedef struct {
    logic [9:0]  count;
    longint      head [3];
    longint      cen  [3];
    longint      avo  [3];
    bit          sat;
    bit          bad;
  } agg_t;

  typedef struct {
    logic [1:0]         cmd;
    logic signed [28:0] px, py, pz;
    logic signed [15:0] dx, dy, dz;
    logic [9:0]         q;
    bit                 want_bad;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bna_in_if  in_ch ();
  bna_out_if out_ch ();
  bna_cfg_if cfg_ch ();

  boid_neighbour_aggregation_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // flock mirror
  logic signed [28:0] flock_pos [MAX_BOIDS][3];
  logic signed [15:0] flock_dir [MAX_BOIDS][3];
  int unsigned        flock_size = 0;
  logic [27:0]        view_r  = VIEW_RESET;
  logic [27:0]        avoid_r = AVOID_RESET;

  agg_t aggregate_q [$];
  bit   failed = 1'b0;
  int   idle_pct = 0;
  int   stall_pct = 0;
  bit   cur_want_bad = 1'b0;

  function automatic longint clamp_add(longint acc, longint dlt, int w, inout bit flag);
    longint hi, lo, r;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    r = acc + dlt;
    if (r > hi) begin r = hi; flag = 1'b1; end
    if (r < lo) begin r = lo; flag = 1'b1; end
    return r;
  endfunction

  function automatic agg_t bad_aggregate();
    agg_t r;
    r.count = '0;
    for (int a = 0; a < 3; a++) begin r.head[a] = 0; r.cen[a] = 0; r.avo[a] = 0; end
    r.sat = 1'b0;
    r.bad = 1'b1;
    return r;
  endfunction

  function automatic agg_t aggregate_of(int unsigned q);
    agg_t r;
    longint off [3];
    longint unsigned m, d, vr2, ar2, recip;
    longint t;
    int unsigned cnt;
    r = bad_aggregate();
    if (q >= flock_size) return r;
    r.bad = 1'b0;
    cnt = 0;
    vr2 = longint'(view_r) * longint'(view_r);
    ar2 = longint'(avoid_r) * longint'(avoid_r);
    for (int unsigned b = 0; b < flock_size; b++) begin
      if (b == q) continue;
      d = 0;
      for (int a = 0; a < 3; a++) begin
        off[a] = longint'(flock_pos[b][a]) - longint'(flock_pos[q][a]);
        m = (off[a] < 0) ? -off[a] : off[a];
        d += m * m;
      end
      if (d >= vr2) continue;
      if (cnt < 1023) cnt++; else r.sat = 1'b1;
      for (int a = 0; a < 3; a++) begin
        r.head[a] = clamp_add(r.head[a], longint'(flock_dir[b][a]), 32, r.sat);
        r.cen[a]  = clamp_add(r.cen[a], longint'(flock_pos[b][a]), 48, r.sat);
      end
      // coincident boids count but push nothing
      if (d < ar2 && d != 0) begin
        recip = (64'd1 << 62) / d;
        for (int a = 0; a < 3; a++) begin
          m = (off[a] < 0) ? -off[a] : off[a];
          t = longint'((m * recip) >> 30);
          if (off[a] < 0) t = -t;
          r.avo[a] = clamp_add(r.avo[a], -t, 48, r.sat);
        end
      end
    end
    r.count = cnt[9:0];
    return r;
  endfunction

  task automatic cmp_field(string name, longint e, longint a);
    if (e != a) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      failed = 1'b1;
    end
  endtask

  // accepted words on all three channels
  always @(posedge clk_i) begin
    agg_t e, g;
    if (rst_ni) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == REG_VIEW_RADIUS) view_r = cfg_ch.data;
        else if (cfg_ch.index == REG_AVOID_RADIUS) avoid_r = cfg_ch.data;
      end
      if (out_ch.valid && out_ch.ready) begin
        g.count = out_ch.neighbour_count;
        g.head[0] = out_ch.heading_sum_x; g.head[1] = out_ch.heading_sum_y;
        g.head[2] = out_ch.heading_sum_z;
        g.cen[0] = out_ch.centre_sum_x; g.cen[1] = out_ch.centre_sum_y;
        g.cen[2] = out_ch.centre_sum_z;
        g.avo[0] = out_ch.avoid_sum_x; g.avo[1] = out_ch.avoid_sum_y;
        g.avo[2] = out_ch.avoid_sum_z;
        g.sat = out_ch.saturated;
        g.bad = out_ch.bad_index;
        if (aggregate_q.size() == 0) begin
          $error("result word with nothing expected");
          failed = 1'b1;
        end else begin
          e = aggregate_q.pop_front();
          cmp_field("neighbour_count", e.count, g.count);
          cmp_field("heading_sum_x", e.head[0], g.head[0]);
          cmp_field("heading_sum_y", e.head[1], g.head[1]);
          cmp_field("heading_sum_z", e.head[2], g.head[2]);
          cmp_field("centre_sum_x", e.cen[0], g.cen[0]);
          cmp_field("centre_sum_y", e.cen[1], g.cen[1]);
          cmp_field("centre_sum_z", e.cen[2], g.cen[2]);
          cmp_field("avoid_sum_x", e.avo[0], g.avo[0]);
          cmp_field("avoid_sum_y", e.avo[1], g.avo[1]);
          cmp_field("avoid_sum_z", e.avo[2], g.avo[2]);
          cmp_field("saturated", e.sat, g.sat);
          cmp_field("bad_index", e.bad, g.bad);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.command)
          CMD_LOAD: if (flock_size < MAX_BOIDS) begin
            flock_pos[flock_size][0] = in_ch.pos_x;
            flock_pos[flock_size][1] = in_ch.pos_y;
            flock_pos[flock_size][2] = in_ch.pos_z;
            flock_dir[flock_size][0] = in_ch.dir_x;
            flock_dir[flock_size][1] = in_ch.dir_y;
            flock_dir[flock_size][2] = in_ch.dir_z;
            flock_size++;
          end
          CMD_CLEAR: flock_size = 0;
          CMD_QUERY: aggregate_q.insert(aggregate_q.size(),
                                        cur_want_bad ? bad_aggregate()
                                        : aggregate_of(in_ch.query_index));
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk_i) out_ch.ready <= ($urandom_range(99) >= stall_pct);

  task automatic send(logic [1:0] cmd, longint x, longint y, longint z,
                      logic [15:0] a, logic [15:0] b, logic [15:0] c,
                      logic [9:0] q, bit want_bad = 1'b0);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.pos_x <= x[28:0]; in_ch.pos_y <= y[28:0]; in_ch.pos_z <= z[28:0];
    in_ch.dir_x <= a; in_ch.dir_y <= b; in_ch.dir_z <= c;
    in_ch.query_index <= q;
    cur_want_bad <= want_bad;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic load_near(longint bx, longint by, longint bz, longint spread);
    longint o [3];
    for (int a = 0; a < 3; a++) o[a] = longint'($urandom_range(0, 2 * spread)) - spread;
    if ($urandom_range(15) == 0)
      send(CMD_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    else
      send(CMD_LOAD, bx + o[0], by + o[1], bz + o[2], $urandom, $urandom, $urandom,
           $urandom);
  endtask

  // wait out outstanding results and the tail of the last load
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (aggregate_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [27:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  row_t dir_tab [19];

  initial begin
    int items, n, phase, episode;
    longint bx, by, bz, spread;
    logic [27:0] vr, ar;
    in_ch.valid = 1'b0; in_ch.command = CMD_LOAD;
    in_ch.pos_x = '0; in_ch.pos_y = '0; in_ch.pos_z = '0;
    in_ch.dir_x = '0; in_ch.dir_y = '0; in_ch.dir_z = '0; in_ch.query_index = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.index = REG_VIEW_RADIUS; cfg_ch.data = '0;
    dir_tab = '{
      '{CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 1'b1},                 // empty flock
      '{CMD_LOAD, 268435455, 268435455, 268435455, 32767, 32767, 32767, 0, 1'b0},
      '{CMD_LOAD, -268435456, -268435456, -268435456, -32768, -32768, -32768, 1023, 1'b0},
      '{CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 1'b0},
      '{CMD_QUERY, 0, 0, 0, 0, 0, 0, 2, 1'b1},
      '{CMD_LOAD, 0, 0, 0, 0, 0, 0, 0, 1'b0},
      '{CMD_LOAD, 0, 0, 0, 1, 1, 1, 0, 1'b0},                  // coincident pair
      '{CMD_LOAD, 32768, 0, 0, -1, -1, -1, 0, 1'b0},
      '{CMD_LOAD, 0, -196608, 0, 16384, 0, -16384, 0, 1'b0},
      '{CMD_QUERY, 0, 0, 0, 0, 0, 0, 2, 1'b0},
      '{CMD_QUERY, 0, 0, 0, 0, 0, 0, 3, 1'b0},
      '{CMD_QUERY, 0, 0, 0, 0, 0, 0, 4, 1'b0},
      '{CMD_QUERY, 0, 0, 0, 0, 0, 0, 5, 1'b0},
      '{CMD_NOISE, -1, -1, -1, -1, -1, -1, 1023, 1'b0},
      '{CMD_QUERY, 0, 0, 0, 0, 0, 0, 1023, 1'b1},
      '{CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 1'b0},
      '{CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 1'b1},
      '{CMD_LOAD, 100, 200, 300, 5, 6, 7, 0, 1'b0},
      '{CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 1'b0}                  // lone boid
    };
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i])
      send(dir_tab[i].cmd, dir_tab[i].px, dir_tab[i].py, dir_tab[i].pz, dir_tab[i].dx,
           dir_tab[i].dy, dir_tab[i].dz, dir_tab[i].q, dir_tab[i].want_bad);

    items = 0;
    episode = 0;
    while (items < 560) begin
      phase = items * 4 / 560;
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 46; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 46; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      if (episode < 4 || $urandom_range(3) == 0) begin
        case (episode)
          0: begin vr = '0; ar = '0; end
          1: begin vr = RADIUS_MAX; ar = RADIUS_MAX; end
          2: begin vr = RADIUS_MAX; ar = '0; end
          3: begin vr = VIEW_RESET; ar = AVOID_RESET; end
          default: begin
            vr = ($urandom_range(3) == 0) ? 28'($urandom) : 28'($urandom_range(1 << 20));
            ar = ($urandom_range(3) == 0) ? 28'($urandom) : 28'($urandom_range(1 << 19));
          end
        endcase
        settle();
        write_reg(REG_VIEW_RADIUS, vr);
        write_reg(REG_AVOID_RADIUS, ar);
      end
      episode++;
      send(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      items++;
      n = $urandom_range(2, 20);
      bx = longint'($signed(28'($urandom)));
      by = longint'($signed(28'($urandom)));
      bz = longint'($signed(28'($urandom)));
      spread = longint'($urandom_range(1, 8)) * ONE_Q16;
      for (int i = 0; i < n; i++) begin
        load_near(bx, by, bz, spread);
        items++;
        if ($urandom_range(19) == 0)
          send(CMD_NOISE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom);
        if ($urandom_range(14) == 0) begin
          send(CMD_QUERY, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               10'($urandom_range(i)));
          items++;
        end
      end
      repeat ($urandom_range(2, 6)) begin
        send(CMD_QUERY, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(n - 1)));
        items++;
      end
    end

    settle();
    repeat (100) @(posedge clk_i);
    if (!failed && aggregate_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/bna_pkg.sv
src/bna_if.sv
src/bna_store.sv
src/bna_div.sv
src/boid_neighbour_aggregation_top.sv
verif/tb_top.sv
